// ===== hdl/billboard_quad_corners_core_assert.svh =====
// assertion macros used by the checker file
`ifndef BILLBOARD_QUAD_CORNERS_CORE_ASSERT_SVH
`define BILLBOARD_QUAD_CORNERS_CORE_ASSERT_SVH

// same-cycle implication
`define BQC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bqc assertion failed");

// next-cycle implication
`define BQC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bqc assertion failed");

`endif

// ===== hdl/bqc_pkg.sv =====
// shared types, constants and helper functions of the billboard corner block
package bqc_pkg;

  localparam int unsigned IN_W    = 32;
  localparam int unsigned MAG_W   = 33;
  localparam int unsigned SCL_W   = 30;
  localparam int unsigned UNIT_W  = 31;
  localparam int unsigned SQ_W    = 62;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned NUM_W   = 3;
  localparam int unsigned SHIFT_W = 6;

  localparam logic [IDX_W-1:0] REG_QUAD_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_QUAD_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] QUAD_SIZE_RESET = 31'd65536;

  localparam logic [NUM_W-1:0] LAST_CORNER = 3'd5;

  // per corner: 1 where the right / up offset is subtracted
  localparam logic [5:0] SR_NEG = 6'b100110;
  localparam logic [5:0] SU_NEG = 6'b001101;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  typedef struct packed {
    logic signed [IN_W-1:0] org_x;
    logic signed [IN_W-1:0] org_y;
    logic signed [IN_W-1:0] org_z;
    logic [SCL_W-1:0]       bx;
    logic [SCL_W-1:0]       bz;
    logic [SCL_W-1:0]       ax;
    logic [SCL_W-1:0]       ay;
    logic [SCL_W-1:0]       az;
    logic                   bx_neg;
    logic                   bz_neg;
    logic                   ay_neg;
    logic                   degen;
  } item_t;

  function automatic logic [SHIFT_W-1:0] msb_pos(input logic [MAG_W-1:0] m);
    logic [SHIFT_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) p = SHIFT_W'(i);
    end
    return p;
  endfunction

  // bring the word so that the top magnitude lands in [2^29, 2^30)
  function automatic logic [SCL_W-1:0] scale_mag(input logic [MAG_W-1:0] m,
                                                 input logic [SHIFT_W-1:0] p);
    logic [MAG_W-1:0] t;
    if (p >= SHIFT_W'(SCL_W - 1)) begin
      t = m >> (p - SHIFT_W'(SCL_W - 1));
    end else begin
      t = m << (SHIFT_W'(SCL_W - 1) - p);
    end
    return t[SCL_W-1:0];
  endfunction

endpackage

// ===== hdl/billboard_quad_corners_core.sv =====
// top level of the camera-facing billboard corner generator
//
//  channel   handshake        accepted when       payload
//  input     push / full      push && !full       camera_*_i, origin_*_i
//  result    empty / pop      pop && !empty       vertex_*_o, last_vertex_o, degenerate_o
//  config    cfg_we_i         cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// a word in the back needs three floor square roots and
// four quotients, each one result bit per cycle on a shared root unit and divider
// degenerate words skip the arithmetic
// the front and a two-word queue keep taking words while the back works, until both are full
// reset is asynchronous and leaves both size registers at 1.0
module billboard_quad_corners_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic signed [bqc_pkg::IN_W-1:0] camera_x_i,
  input  logic signed [bqc_pkg::IN_W-1:0] camera_y_i,
  input  logic signed [bqc_pkg::IN_W-1:0] camera_z_i,
  input  logic signed [bqc_pkg::IN_W-1:0] origin_x_i,
  input  logic signed [bqc_pkg::IN_W-1:0] origin_y_i,
  input  logic signed [bqc_pkg::IN_W-1:0] origin_z_i,
  input  logic                            pop,
  output logic                            empty,
  output logic signed [bqc_pkg::IN_W-1:0] vertex_x_o,
  output logic signed [bqc_pkg::IN_W-1:0] vertex_y_o,
  output logic signed [bqc_pkg::IN_W-1:0] vertex_z_o,
  output logic [bqc_pkg::NUM_W-1:0]       vertex_number_o,
  output logic                            last_vertex_o,
  output logic                            degenerate_o,
  input  logic                            cfg_we_i,
  input  logic [bqc_pkg::IDX_W-1:0]       cfg_idx_i,
  input  logic [bqc_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import bqc_pkg::*;

  logic [CFG_W-1:0] width_q, height_q;
  logic             in_ready, q_push, q_full, q_pop, q_empty;
  item_t            q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= QUAD_SIZE_RESET;
      height_q <= QUAD_SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUAD_WIDTH:  width_q  <= cfg_wdata_i;
        REG_QUAD_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign full = !in_ready;

  bqc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_ready_o (in_ready),
    .camera_x_i (camera_x_i),
    .camera_y_i (camera_y_i),
    .camera_z_i (camera_z_i),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .origin_z_i (origin_z_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_wdata)
  );

  bqc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  bqc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (q_rdata),
    .q_pop_o         (q_pop),
    .quad_width_i    (width_q),
    .quad_height_i   (height_q),
    .pop_i           (pop),
    .empty_o         (empty),
    .vertex_x_o      (vertex_x_o),
    .vertex_y_o      (vertex_y_o),
    .vertex_z_o      (vertex_z_o),
    .vertex_number_o (vertex_number_o),
    .last_vertex_o   (last_vertex_o),
    .degenerate_o    (degenerate_o)
  );

endmodule

// ===== hdl/bqc_queue.sv =====
// two-word queue between the front and the back
module bqc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  bqc_pkg::item_t wdata_i,
  input  logic          pop_i,
  output logic          empty_o,
  output bqc_pkg::item_t rdata_o
);
  import bqc_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, rd_q;
  logic [QUEUE_AW:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hdl/bqc_front.sv =====
// front: takes words, forms the direction, flags degenerate, scales magnitudes
module bqc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [bqc_pkg::IN_W-1:0] camera_x_i,
  input  logic signed [bqc_pkg::IN_W-1:0] camera_y_i,
  input  logic signed [bqc_pkg::IN_W-1:0] camera_z_i,
  input  logic signed [bqc_pkg::IN_W-1:0] origin_x_i,
  input  logic signed [bqc_pkg::IN_W-1:0] origin_y_i,
  input  logic signed [bqc_pkg::IN_W-1:0] origin_z_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output bqc_pkg::item_t                 q_item_o
);
  import bqc_pkg::*;

  logic                   v1_q;
  logic signed [IN_W-1:0] ox_q, oy_q, oz_q;
  logic [MAG_W-1:0]       dxm_q, dym_q, dzm_q, max2_q, max3_q;
  logic                   dxn_q, dyn_q, dzn_q, degen_q;

  logic signed [MAG_W-1:0] dx, dy, dz;
  logic [MAG_W-1:0]        dxm, dym, dzm, max2, max3;
  logic [SHIFT_W-1:0]      p2, p3;

  assign dx  = MAG_W'(camera_x_i) - MAG_W'(origin_x_i);
  assign dy  = MAG_W'(camera_y_i) - MAG_W'(origin_y_i);
  assign dz  = MAG_W'(camera_z_i) - MAG_W'(origin_z_i);
  assign dxm = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
  assign dym = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  assign dzm = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
  assign max2 = (dxm > dzm) ? dxm : dzm;
  assign max3 = (max2 > dym) ? max2 : dym;

  assign in_ready_o = !v1_q || !q_full_i;
  assign q_push_o   = v1_q;

  assign p2 = msb_pos(max2_q);
  assign p3 = msb_pos(max3_q);

  always_comb begin
    q_item_o.org_x  = ox_q;
    q_item_o.org_y  = oy_q;
    q_item_o.org_z  = oz_q;
    q_item_o.bx     = scale_mag(dxm_q, p2);
    q_item_o.bz     = scale_mag(dzm_q, p2);
    q_item_o.ax     = scale_mag(dxm_q, p3);
    q_item_o.ay     = scale_mag(dym_q, p3);
    q_item_o.az     = scale_mag(dzm_q, p3);
    q_item_o.bx_neg = dxn_q;
    q_item_o.bz_neg = dzn_q;
    q_item_o.ay_neg = dyn_q;
    q_item_o.degen  = degen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      oz_q    <= origin_z_i;
      dxm_q   <= dxm;
      dym_q   <= dym;
      dzm_q   <= dzm;
      max2_q  <= max2;
      max3_q  <= max3;
      dxn_q   <= dx[MAG_W-1];
      dyn_q   <= dy[MAG_W-1];
      dzn_q   <= dz[MAG_W-1];
      degen_q <= (dx == '0) && (dz == '0);
    end
  end

endmodule

// ===== hdl/bqc_isqrt.sv =====
// floor square root, one result bit per cycle
module bqc_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bqc_pkg::SQ_W-1:0]   rad_i,
  output logic                       done_o,
  output logic [bqc_pkg::UNIT_W-1:0] root_o
);
  import bqc_pkg::*;

  logic              busy_q, done_q;
  logic [4:0]        cnt_q;
  logic [SQ_W-1:0]   rad_q;
  logic [32:0]       rem_q;
  logic [UNIT_W-1:0] root_q;
  logic [34:0]       rem_sh, trial;
  logic              ge;

  assign rem_sh = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'(UNIT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (ge) begin
        rem_q  <= 33'(rem_sh - trial);
        root_q <= {root_q[UNIT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[32:0];
        root_q <= {root_q[UNIT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/bqc_div.sv =====
// rounded quotient of num * 2^30 by den, one quotient bit per cycle
module bqc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bqc_pkg::UNIT_W-1:0] num_i,
  input  logic [bqc_pkg::UNIT_W-1:0] den_i,
  output logic                       done_o,
  output logic [bqc_pkg::UNIT_W-1:0] quo_o
);
  import bqc_pkg::*;

  logic              busy_q, done_q;
  logic [4:0]        cnt_q;
  logic [UNIT_W-1:0] rem_q, low_q, den_q, quo_q;
  logic [SQ_W-1:0]   dvd;
  logic [UNIT_W:0]   rem_sh;
  logic              ge;

  assign dvd    = {1'b0, num_i, {(SQ_W-UNIT_W-1){1'b0}}} + SQ_W'(den_i >> 1);
  assign rem_sh = {rem_q, low_q[UNIT_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'(UNIT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dvd[SQ_W-1:UNIT_W];
      low_q <= dvd[UNIT_W-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      low_q <= low_q << 1;
      quo_q <= {quo_q[UNIT_W-2:0], ge};
      if (ge) rem_q <= UNIT_W'(rem_sh - {1'b0, den_q});
      else rem_q <= rem_sh[UNIT_W-1:0];
    end
  end

endmodule

// ===== hdl/bqc_back.sv =====
// back: squares, roots, quotients, scaling and the six corner words
module bqc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  bqc_pkg::item_t                 q_item_i,
  output logic                           q_pop_o,
  input  logic [bqc_pkg::CFG_W-1:0]      quad_width_i,
  input  logic [bqc_pkg::CFG_W-1:0]      quad_height_i,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic signed [bqc_pkg::IN_W-1:0] vertex_x_o,
  output logic signed [bqc_pkg::IN_W-1:0] vertex_y_o,
  output logic signed [bqc_pkg::IN_W-1:0] vertex_z_o,
  output logic [bqc_pkg::NUM_W-1:0]      vertex_number_o,
  output logic                           last_vertex_o,
  output logic                           degenerate_o
);
  import bqc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  localparam logic [2:0] SQ_LAST   = 3'd4;
  localparam logic [2:0] SQRT_LAST = 3'd2;
  localparam logic [2:0] DIV_LAST  = 3'd3;
  localparam logic [2:0] MUL_LAST  = 3'd6;
  localparam logic [2:0] MUL_DRAIN = 3'd7;

  localparam int unsigned SUM_W = 35;

  logic [2:0] state_q, state_d, step_q, step_d;
  logic       run_q;
  item_t      item_q;

  logic [SQ_W-1:0]   sq_q [5];
  logic [UNIT_W-1:0] r_q, len_q, rr_q;
  logic [UNIT_W-1:0] rv0_q, rv2_q, sy_q, cy_q, uv0_q, uv2_q;
  logic [UNIT_W-1:0] offr0_q, offr2_q, offu0_q, offu1_q, offu2_q;
  logic [SQ_W-1:0]   prod_q;
  logic [2:0]        prod_tgt_q;
  logic              prod_vld_q;

  logic              out_valid_q;
  logic signed [IN_W-1:0] vx_q, vy_q, vz_q;
  logic [NUM_W-1:0]  vnum_q;
  logic              vlast_q, vdeg_q;

  logic              sqrt_start, sqrt_done, div_start, div_done, out_load, out_free;
  logic [SQ_W-1:0]   rad;
  logic [UNIT_W-1:0] root, num, den, quo, mul_a, mul_b;
  logic [SQ_W-1:0]   product;
  logic [SQ_W:0]     rnd;
  logic [UNIT_W-1:0] rnd_res;
  logic              neg_r0, neg_r2, neg_u0, neg_u2, sr_n, su_n;
  logic signed [SUM_W-1:0] sx, sy_sum, sz;

  function automatic logic signed [SUM_W-1:0] sval(input logic [UNIT_W-1:0] m,
                                                   input logic neg);
    logic signed [SUM_W-1:0] v;
    v = $signed({{(SUM_W-UNIT_W){1'b0}}, m});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [IN_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'(2147483647);
    lo = -SUM_W'(2147483647) - SUM_W'(1);
    if (v > hi) return IN_W'(hi);
    if (v < lo) return IN_W'(lo);
    return v[IN_W-1:0];
  endfunction

  bqc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  bqc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    q_pop_o    = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          step_d  = '0;
          state_d = q_item_i.degen ? ST_EMIT : ST_SQ;
        end
      end
      ST_SQ: begin
        step_d = step_q + 1'b1;
        if (step_q == SQ_LAST) begin
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sqrt_start = !run_q;
        if (sqrt_done) begin
          step_d = step_q + 1'b1;
          if (step_q == SQRT_LAST) begin
            step_d  = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        div_start = !run_q;
        if (div_done) begin
          step_d = step_q + 1'b1;
          if (step_q == DIV_LAST) begin
            step_d  = '0;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == MUL_DRAIN) begin
          step_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          step_d   = step_q + 1'b1;
          if (step_q == 3'(LAST_CORNER)) begin
            step_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  // root and quotient operands
  always_comb begin
    case (step_q)
      3'd0:    rad = sq_q[0] + sq_q[1];
      3'd1:    rad = sq_q[2] + sq_q[3] + sq_q[4];
      default: rad = sq_q[2] + sq_q[4];
    endcase
    case (step_q)
      3'd0:    begin num = UNIT_W'(item_q.bz); den = r_q;   end
      3'd1:    begin num = UNIT_W'(item_q.bx); den = r_q;   end
      3'd2:    begin num = UNIT_W'(item_q.ay); den = len_q; end
      default: begin num = rr_q;               den = len_q; end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_SQ) begin
      case (step_q)
        3'd0:    mul_a = UNIT_W'(item_q.bx);
        3'd1:    mul_a = UNIT_W'(item_q.bz);
        3'd2:    mul_a = UNIT_W'(item_q.ax);
        3'd3:    mul_a = UNIT_W'(item_q.ay);
        default: mul_a = UNIT_W'(item_q.az);
      endcase
      mul_b = mul_a;
    end else begin
      case (step_q)
        3'd0:    begin mul_a = rv2_q; mul_b = sy_q;                 end
        3'd1:    begin mul_a = rv0_q; mul_b = sy_q;                 end
        3'd2:    begin mul_a = rv0_q; mul_b = quad_width_i;         end
        3'd3:    begin mul_a = rv2_q; mul_b = quad_width_i;         end
        3'd4:    begin mul_a = uv0_q; mul_b = quad_height_i;        end
        3'd5:    begin mul_a = cy_q;  mul_b = quad_height_i;        end
        default: begin mul_a = uv2_q; mul_b = quad_height_i;        end
      endcase
    end
  end

  assign product = SQ_W'(mul_a * mul_b);

  always_comb begin
    if (prod_tgt_q <= 3'd1) begin
      rnd     = {1'b0, prod_q} + (SQ_W+1)'(64'd1 << 29);
      rnd_res = UNIT_W'(rnd >> 30);
    end else begin
      rnd     = {1'b0, prod_q} + (SQ_W+1)'(64'd1 << 30);
      rnd_res = UNIT_W'(rnd >> 31);
    end
  end

  // corner sums
  assign neg_r0 = item_q.bz_neg;
  assign neg_r2 = !item_q.bx_neg;
  assign neg_u0 = neg_r2 ^ item_q.ay_neg;
  assign neg_u2 = !neg_r0 ^ item_q.ay_neg;
  assign sr_n   = SR_NEG[step_q];
  assign su_n   = SU_NEG[step_q];
  assign sx     = SUM_W'(item_q.org_x) + sval(offr0_q, neg_r0 ^ sr_n)
                + sval(offu0_q, neg_u0 ^ su_n);
  assign sy_sum = SUM_W'(item_q.org_y) + sval(offu1_q, su_n);
  assign sz     = SUM_W'(item_q.org_z) + sval(offr2_q, neg_r2 ^ sr_n)
                + sval(offu2_q, neg_u2 ^ su_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      run_q       <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      prod_vld_q <= (state_q == ST_MUL) && (step_q <= MUL_LAST);
      if (sqrt_start || div_start) run_q <= 1'b1;
      else if (sqrt_done || div_done) run_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q  <= q_item_i;
      offr0_q <= '0;
      offr2_q <= '0;
      offu0_q <= '0;
      offu1_q <= '0;
      offu2_q <= '0;
    end
    if (state_q == ST_SQ) sq_q[step_q] <= product;
    if (sqrt_done) begin
      case (step_q)
        3'd0:    r_q   <= root;
        3'd1:    len_q <= root;
        default: rr_q  <= root;
      endcase
    end
    if (div_done) begin
      case (step_q)
        3'd0:    rv0_q <= quo;
        3'd1:    rv2_q <= quo;
        3'd2:    sy_q  <= quo;
        default: cy_q  <= quo;
      endcase
    end
    if (state_q == ST_MUL) begin
      prod_q     <= product;
      prod_tgt_q <= step_q;
    end
    if (prod_vld_q) begin
      case (prod_tgt_q)
        3'd0:    uv0_q   <= rnd_res;
        3'd1:    uv2_q   <= rnd_res;
        3'd2:    offr0_q <= rnd_res;
        3'd3:    offr2_q <= rnd_res;
        3'd4:    offu0_q <= rnd_res;
        3'd5:    offu1_q <= rnd_res;
        default: offu2_q <= rnd_res;
      endcase
    end
    if (out_load) begin
      vx_q    <= sat(sx);
      vy_q    <= sat(sy_sum);
      vz_q    <= sat(sz);
      vnum_q  <= NUM_W'(step_q);
      vlast_q <= (step_q == 3'(LAST_CORNER));
      vdeg_q  <= item_q.degen;
    end
  end

  assign empty_o         = !out_valid_q;
  assign vertex_x_o      = vx_q;
  assign vertex_y_o      = vy_q;
  assign vertex_z_o      = vz_q;
  assign vertex_number_o = vnum_q;
  assign last_vertex_o   = vlast_q;
  assign degenerate_o    = vdeg_q;

endmodule

// ===== hdl/bqc_checker.sv =====
// port-level checks of the billboard corner block, bound to the top level
`include "billboard_quad_corners_core_assert.svh"

module bqc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            pop,
  input logic                            empty,
  input logic signed [bqc_pkg::IN_W-1:0] vertex_x_o,
  input logic [bqc_pkg::NUM_W-1:0]       vertex_number_o,
  input logic                            last_vertex_o
);
  import bqc_pkg::*;

  `BQC_ASSERT_NOW(a_last_flag, !empty, last_vertex_o == (vertex_number_o == LAST_CORNER))
  `BQC_ASSERT_NOW(a_corner_range, !empty, vertex_number_o <= LAST_CORNER)
  `BQC_ASSERT_NEXT(a_word_stays, !empty && !pop, !empty)
  `BQC_ASSERT_NEXT(a_word_holds, !empty && !pop, $stable(vertex_x_o))

endmodule

bind billboard_quad_corners_core bqc_checker u_bqc_checker (.*);
